[hw/rtl/baro_pressure_temp_compensation_unit_defines.svh]
// Assertion macros used by the checker file.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define BPTC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("baro compensation assertion failed");

// Property that must also hold around reset.
`define BPTC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("baro compensation assertion failed");

`endif

[hw/rtl/baro_ptc_pkg.sv]
package baro_ptc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int COEF_W      = 16;
   localparam int RAW_W       = 24;
   localparam int DT_W        = 25;
   localparam int PROD_W      = 42;
   localparam int DTSQ_W      = 50;
   localparam int Q_W         = 18;
   localparam int TEMP_W      = 20;
   localparam int OFF1_W      = 36;
   localparam int SENS1_W     = 35;
   localparam int DTSH_W      = 18;
   localparam int ASQ_W       = 34;
   localparam int OFF2_W      = 38;
   localparam int SENS2_W     = 37;
   localparam int SLO_W       = 19;
   localparam int PART_W      = 43;
   localparam int ACC_W       = 62;
   localparam int T_W         = 43;
   localparam int LATENCY     = 8;

   localparam logic signed [TEMP_W-1:0] TEMP_REF_CENTI = 20'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_OUT_MAX   = 20'sd262143;
   localparam logic signed [TEMP_W-1:0] TEMP_OUT_MIN   = -20'sd262144;
   localparam logic signed [T_W-1:0]    PRESS_OUT_MAX  = 43'sd2147483647;
   localparam logic signed [T_W-1:0]    PRESS_OUT_MIN  = -43'sd2147483648;
   localparam logic signed [PROD_W-1:0] TEMP_DIV_BIAS  = 42'sd8388607;
   localparam logic signed [T_W-1:0]    PRESS_DIV_BIAS = 43'sd32767;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SENS_COEF        = 3'd0,
      REG_OFFSET_COEF      = 3'd1,
      REG_SENS_TEMP_COEF   = 3'd2,
      REG_OFFSET_TEMP_COEF = 3'd3,
      REG_REF_TEMP_WORD    = 3'd4,
      REG_TEMP_SLOPE_COEF  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] sens_coef;
      logic [COEF_W-1:0] offset_coef;
      logic [COEF_W-1:0] sens_temp_coef;
      logic [COEF_W-1:0] offset_temp_coef;
      logic [COEF_W-1:0] ref_temp_word;
      logic [COEF_W-1:0] temp_slope_coef;
   } cfg_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_temperature;
      logic [RAW_W-1:0] raw_pressure;
   } req_payload_type;

   typedef struct packed {
      logic signed [18:0] temperature_centi;
      logic signed [31:0] pressure_pa;
      logic               low_temp_corrected;
   } rsp_payload_type;

   // first-order results handed to the correction stages
   typedef struct packed {
      logic                      valid;
      logic signed [TEMP_W-1:0]  temp;
      logic signed [OFF1_W-1:0]  off;
      logic signed [SENS1_W-1:0] sens;
      logic [DTSH_W-1:0]         dt_sq_shift;
      logic signed [Q_W-1:0]     temp_delta;
      logic                      low;
      logic [RAW_W-1:0]          raw_pressure;
   } front_out_type;

   // corrected terms handed to the pressure stages
   typedef struct packed {
      logic                      valid;
      logic signed [TEMP_W-1:0]  temp;
      logic signed [OFF2_W-1:0]  off;
      logic signed [SENS2_W-1:0] sens;
      logic                      low;
      logic [RAW_W-1:0]          raw_pressure;
   } corr_out_type;

endpackage

[hw/rtl/baro_pressure_temp_compensation_unit.sv]
// Barometer pressure/temperature compensation, eight-stage pipeline.
//
// Command channel: drive req_data with a raw temperature and pressure pair
// and raise start; the pair transfers at a clock edge with start high and
// busy low. busy is always low, so a new pair may transfer every cycle.
// Result channel: rsp_strobe is high for one cycle with rsp_data holding
// temperature (0.01 degC), pressure (Pa) and the low-temperature flag.
// Throughput is one pair per cycle. The pipeline depth is set by the chain
// dT -> dT products -> first-order terms -> square -> correction ->
// split D1*SENS multiply -> recombine -> divide/saturate, one register each.
// The receiver cannot stall; results leave in order, one per transfer.
// Calibration: write csr_data to register csr_index (0..5) with csr_valid;
// csr_ready is always high, unknown indexes are dropped. Write only while no
// pair is in flight.
// Reset (synchronous, active high) clears all calibration words to zero and
// empties the pipeline; no result strobes out of reset.
module baro_pressure_temp_compensation_unit
   import baro_ptc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_payload_type        req_data,
   output logic                   rsp_strobe,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_data
);

   cfg_type       cfg;
   front_out_type front_out;
   corr_out_type  corr_out;
   logic          accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   baro_ptc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   baro_ptc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .cfg      (cfg),
      .out      (front_out)
   );

   baro_ptc_corr u_corr (
      .clock    (clock),
      .reset    (reset),
      .in_stage (front_out),
      .out      (corr_out)
   );

   baro_ptc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (corr_out),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule

[hw/rtl/baro_ptc_csr.sv]
module baro_ptc_csr
   import baro_ptc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_SENS_COEF:        cfg_in.sens_coef        = csr_data;
            REG_OFFSET_COEF:      cfg_in.offset_coef      = csr_data;
            REG_SENS_TEMP_COEF:   cfg_in.sens_temp_coef   = csr_data;
            REG_OFFSET_TEMP_COEF: cfg_in.offset_temp_coef = csr_data;
            REG_REF_TEMP_WORD:    cfg_in.ref_temp_word    = csr_data;
            REG_TEMP_SLOPE_COEF:  cfg_in.temp_slope_coef  = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/baro_ptc_front.sv]
module baro_ptc_front
   import baro_ptc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  req_payload_type in_data,
   input  cfg_type         cfg,
   output front_out_type   out
);

   // stage 1: temperature difference
   logic                     s1_valid_ff;
   logic signed [DT_W-1:0]   s1_dt_ff;
   logic signed [DT_W-1:0]   s1_dt_in;
   logic [RAW_W-1:0]         s1_d1_ff;

   // stage 2: products with dT
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] s2_ptemp_ff, s2_ptemp_in;
   logic signed [PROD_W-1:0] s2_poff_ff, s2_poff_in;
   logic signed [PROD_W-1:0] s2_psens_ff, s2_psens_in;
   logic signed [DTSQ_W-1:0] s2_dtsq_ff, s2_dtsq_in;
   logic [RAW_W-1:0]         s2_d1_ff;

   // stage 3: first-order terms
   front_out_type            s3_ff, s3_in;
   logic signed [PROD_W-1:0] ptemp_adj;
   logic signed [Q_W-1:0]    q;
   logic signed [PROD_W-1:0] off_full, sens_full;

   assign out = s3_ff;

   always_comb begin
      s1_dt_in = $signed({1'b0, in_data.raw_temperature})
               - $signed({1'b0, cfg.ref_temp_word, 8'h00});
   end

   always_comb begin
      s2_ptemp_in = s1_dt_ff * $signed({1'b0, cfg.temp_slope_coef});
      s2_poff_in  = s1_dt_ff * $signed({1'b0, cfg.offset_temp_coef});
      s2_psens_in = s1_dt_ff * $signed({1'b0, cfg.sens_temp_coef});
      s2_dtsq_in  = s1_dt_ff * s1_dt_ff;
   end

   always_comb begin
      // truncating divide by 2^23: bias negative values before the shift
      ptemp_adj = s2_ptemp_ff + (s2_ptemp_ff[PROD_W-1] ? TEMP_DIV_BIAS : '0);
      q         = Q_W'(ptemp_adj >>> 23);
      off_full  = $signed({10'b0, cfg.offset_coef, 16'h0000}) + (s2_poff_ff >>> 7);
      sens_full = $signed({11'b0, cfg.sens_coef, 15'h0000}) + (s2_psens_ff >>> 8);

      s3_in.valid        = s2_valid_ff;
      s3_in.temp         = TEMP_REF_CENTI + TEMP_W'(q);
      s3_in.off          = OFF1_W'(off_full);
      s3_in.sens         = SENS1_W'(sens_full);
      // dT^2 is never negative and stays below 2^48
      s3_in.dt_sq_shift  = s2_dtsq_ff[48:31];
      s3_in.temp_delta   = q;
      s3_in.low          = q[Q_W-1];
      s3_in.raw_pressure = s2_d1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_ff.valid <= s3_in.valid;
      end
      s1_dt_ff           <= s1_dt_in;
      s1_d1_ff           <= in_data.raw_pressure;
      s2_ptemp_ff        <= s2_ptemp_in;
      s2_poff_ff         <= s2_poff_in;
      s2_psens_ff        <= s2_psens_in;
      s2_dtsq_ff         <= s2_dtsq_in;
      s2_d1_ff           <= s1_d1_ff;
      s3_ff.temp         <= s3_in.temp;
      s3_ff.off          <= s3_in.off;
      s3_ff.sens         <= s3_in.sens;
      s3_ff.dt_sq_shift  <= s3_in.dt_sq_shift;
      s3_ff.temp_delta   <= s3_in.temp_delta;
      s3_ff.low          <= s3_in.low;
      s3_ff.raw_pressure <= s3_in.raw_pressure;
   end

endmodule

[hw/rtl/baro_ptc_corr.sv]
module baro_ptc_corr
   import baro_ptc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  front_out_type in_stage,
   output corr_out_type  out
);

   // stage 4: square of the temperature deviation, corrected temperature
   logic                      s4_valid_ff;
   logic [ASQ_W-1:0]          s4_asq_ff, s4_asq_in;
   logic signed [TEMP_W-1:0]  s4_temp_ff, s4_temp_in;
   logic signed [OFF1_W-1:0]  s4_off_ff;
   logic signed [SENS1_W-1:0] s4_sens_ff;
   logic                      s4_low_ff;
   logic [RAW_W-1:0]          s4_d1_ff;
   logic signed [2*Q_W-1:0]   qsq;

   // stage 5: corrected offset and sensitivity
   corr_out_type              s5_ff, s5_in;
   logic [ASQ_W+2:0]          a5;

   assign out = s5_ff;

   always_comb begin
      qsq        = in_stage.temp_delta * in_stage.temp_delta;
      s4_asq_in  = qsq[ASQ_W-1:0];
      s4_temp_in = in_stage.low
                 ? in_stage.temp - $signed({2'b00, in_stage.dt_sq_shift})
                 : in_stage.temp;
   end

   always_comb begin
      a5 = (ASQ_W+3)'(s4_asq_ff) + ((ASQ_W+3)'(s4_asq_ff) << 2);
      s5_in.valid        = s4_valid_ff;
      s5_in.temp         = s4_temp_ff;
      s5_in.off          = OFF2_W'(s4_off_ff)
                         - (s4_low_ff ? $signed({2'b00, a5[ASQ_W+2:1]}) : '0);
      s5_in.sens         = SENS2_W'(s4_sens_ff)
                         - (s4_low_ff ? $signed({2'b00, a5[ASQ_W+2:2]}) : '0);
      s5_in.low          = s4_low_ff;
      s5_in.raw_pressure = s4_d1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else begin
         s4_valid_ff <= in_stage.valid;
         s5_ff.valid <= s5_in.valid;
      end
      s4_asq_ff          <= s4_asq_in;
      s4_temp_ff         <= s4_temp_in;
      s4_off_ff          <= in_stage.off;
      s4_sens_ff         <= in_stage.sens;
      s4_low_ff          <= in_stage.low;
      s4_d1_ff           <= in_stage.raw_pressure;
      s5_ff.temp         <= s5_in.temp;
      s5_ff.off          <= s5_in.off;
      s5_ff.sens         <= s5_in.sens;
      s5_ff.low          <= s5_in.low;
      s5_ff.raw_pressure <= s5_in.raw_pressure;
   end

endmodule

[hw/rtl/baro_ptc_press.sv]
module baro_ptc_press
   import baro_ptc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  corr_out_type    in_stage,
   output logic            out_valid,
   output rsp_payload_type out_data
);

   // stage 6: D1 * SENS as two partial products
   logic                         s6_valid_ff;
   logic [PART_W-1:0]            s6_plo_ff, s6_plo_in;
   logic signed [PART_W-1:0]     s6_phi_ff, s6_phi_in;
   logic signed [OFF2_W-1:0]     s6_off_ff;
   logic signed [TEMP_W-1:0]     s6_temp_ff;
   logic                         s6_low_ff;
   logic signed [SENS2_W-SLO_W-1:0] sens_hi;

   // stage 7: recombine, scale by 2^-21, remove offset
   logic                         s7_valid_ff;
   logic signed [T_W-1:0]        s7_t_ff, s7_t_in;
   logic signed [TEMP_W-1:0]     s7_temp_ff;
   logic                         s7_low_ff;
   logic signed [ACC_W-1:0]      acc;
   logic signed [ACC_W-1:0]      t_full;

   // stage 8: truncating divide by 2^15, saturation, result register
   logic                         s8_valid_ff;
   rsp_payload_type              s8_data_ff, s8_data_in;
   logic signed [T_W-1:0]        t_adj;
   logic signed [T_W-1:0]        pq;

   assign out_valid = s8_valid_ff;
   assign out_data  = s8_data_ff;

   always_comb begin
      sens_hi   = in_stage.sens[SENS2_W-1:SLO_W];
      s6_plo_in = PART_W'(in_stage.raw_pressure * in_stage.sens[SLO_W-1:0]);
      s6_phi_in = $signed({1'b0, in_stage.raw_pressure}) * sens_hi;
   end

   always_comb begin
      acc     = ($signed(ACC_W'(s6_phi_ff)) <<< SLO_W)
              + $signed({(ACC_W-PART_W)'(0), s6_plo_ff});
      t_full  = (acc >>> 21) - ACC_W'(s6_off_ff);
      s7_t_in = T_W'(t_full);
   end

   always_comb begin
      t_adj = s7_t_ff + (s7_t_ff[T_W-1] ? PRESS_DIV_BIAS : '0);
      pq    = t_adj >>> 15;
      if (pq > PRESS_OUT_MAX) begin
         s8_data_in.pressure_pa = 32'sh7FFF_FFFF;
      end else if (pq < PRESS_OUT_MIN) begin
         s8_data_in.pressure_pa = 32'sh8000_0000;
      end else begin
         s8_data_in.pressure_pa = pq[31:0];
      end
      if (s7_temp_ff > TEMP_OUT_MAX) begin
         s8_data_in.temperature_centi = TEMP_OUT_MAX[18:0];
      end else if (s7_temp_ff < TEMP_OUT_MIN) begin
         s8_data_in.temperature_centi = TEMP_OUT_MIN[18:0];
      end else begin
         s8_data_in.temperature_centi = s7_temp_ff[18:0];
      end
      s8_data_in.low_temp_corrected = s7_low_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= in_stage.valid;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_plo_ff  <= s6_plo_in;
      s6_phi_ff  <= s6_phi_in;
      s6_off_ff  <= in_stage.off;
      s6_temp_ff <= in_stage.temp;
      s6_low_ff  <= in_stage.low;
      s7_t_ff    <= s7_t_in;
      s7_temp_ff <= s6_temp_ff;
      s7_low_ff  <= s6_low_ff;
      s8_data_ff <= s8_data_in;
   end

endmodule

[hw/rtl/baro_ptc_checker.sv]
`include "baro_pressure_temp_compensation_unit_defines.svh"

module baro_ptc_checker
   import baro_ptc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input rsp_payload_type        rsp_data
);

   logic reading_low;

   assign reading_low = rsp_data.temperature_centi < TEMP_REF_CENTI;

   // every transfer is followed by a result strobe
   `BPTC_ASSERT(a_rsp_follows_req, clock, reset, (start && !busy) |-> ##LATENCY rsp_strobe)

   // no result without a matching transfer
   `BPTC_ASSERT(a_rsp_has_req, clock, reset, rsp_strobe |-> $past(start && !busy, LATENCY))

   // correction flag agrees with the reported temperature
   `BPTC_ASSERT(a_low_flag, clock, reset, rsp_strobe |-> (rsp_data.low_temp_corrected == reading_low))

   // pipeline is empty right after reset
   `BPTC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_strobe)

endmodule

bind baro_pressure_temp_compensation_unit baro_ptc_checker u_baro_ptc_checker (.*);
